// File: sv/dbtm_pkg.sv
// Shared types and constants for the dual biquad threshold monitor.
// No dependencies; every other file in this folder imports this package.
package dbtm_pkg;

  // Default build values for the top-level parameters.
  localparam int SAMPLE_BITS_DEF = 12;
  localparam int COEF_FRAC_DEF   = 14;

  // Fixed field widths.
  localparam int COEF_W    = 16;
  localparam int HIST_W    = 24;
  localparam int HIST_FRAC = 10;
  localparam int FILT_W    = HIST_W - HIST_FRAC;
  localparam int LIMIT_W   = 13;
  localparam int STEP_W    = 16;
  localparam int STAMP_W   = 32;

  // Saturation bounds of the stored filter output.
  localparam int HIST_MAX = 2 ** (HIST_W - 1) - 1;
  localparam int HIST_MIN = -(2 ** (HIST_W - 1));

  // Configuration port.
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  // Register reset values.
  localparam int B0_RST    = 819;
  localparam int B1_RST    = 1638;
  localparam int B2_RST    = 819;
  localparam int A1_RST    = 4915;
  localparam int A2_RST    = -1638;
  localparam int LIMIT_RST = 800;
  localparam int STEP_RST  = 10;

  // Register word indexes (byte address divided by four).
  typedef enum logic [ADDR_W-3:0] {
    REG_B0    = 3'd0,
    REG_B1    = 3'd1,
    REG_B2    = 3'd2,
    REG_A1    = 3'd3,
    REG_A2    = 3'd4,
    REG_LIMIT = 3'd5,
    REG_STEP  = 3'd6
  } dbtm_reg_e;

  // Current configuration as seen by the datapath.
  typedef struct packed {
    logic signed [COEF_W-1:0] b0;
    logic signed [COEF_W-1:0] b1;
    logic signed [COEF_W-1:0] b2;
    logic signed [COEF_W-1:0] a1;
    logic signed [COEF_W-1:0] a2;
    logic [LIMIT_W-1:0]       limit;
    logic [STEP_W-1:0]        step;
  } dbtm_cfg_t;

  // Load enables of the filter pipeline stages.
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
  } dbtm_ld_t;

endpackage

// File: sv/dbtm_regs.sv
// Configuration register file with an APB-style port.
// Depends on dbtm_pkg for the register map and the configuration struct.
module dbtm_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbtm_pkg::ADDR_W-1:0] paddr,
  input  logic [dbtm_pkg::DATA_W-1:0] pwdata,
  output logic [dbtm_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dbtm_pkg::dbtm_cfg_t         cfg_o
);
  import dbtm_pkg::*;

  dbtm_cfg_t cfg_q;
  logic      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  // Register writes; unknown word indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.b0    <= COEF_W'(B0_RST);
      cfg_q.b1    <= COEF_W'(B1_RST);
      cfg_q.b2    <= COEF_W'(B2_RST);
      cfg_q.a1    <= COEF_W'(A1_RST);
      cfg_q.a2    <= COEF_W'(A2_RST);
      cfg_q.limit <= LIMIT_W'(LIMIT_RST);
      cfg_q.step  <= STEP_W'(STEP_RST);
    end else if (wr_en) begin
      unique case (paddr[ADDR_W-1:2])
        REG_B0:    cfg_q.b0    <= pwdata[COEF_W-1:0];
        REG_B1:    cfg_q.b1    <= pwdata[COEF_W-1:0];
        REG_B2:    cfg_q.b2    <= pwdata[COEF_W-1:0];
        REG_A1:    cfg_q.a1    <= pwdata[COEF_W-1:0];
        REG_A2:    cfg_q.a2    <= pwdata[COEF_W-1:0];
        REG_LIMIT: cfg_q.limit <= pwdata[LIMIT_W-1:0];
        REG_STEP:  cfg_q.step  <= pwdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back; coefficients come back sign-extended.
  always_comb begin
    unique case (paddr[ADDR_W-1:2])
      REG_B0:    prdata = DATA_W'(cfg_q.b0);
      REG_B1:    prdata = DATA_W'(cfg_q.b1);
      REG_B2:    prdata = DATA_W'(cfg_q.b2);
      REG_A1:    prdata = DATA_W'(cfg_q.a1);
      REG_A2:    prdata = DATA_W'(cfg_q.a2);
      REG_LIMIT: prdata = DATA_W'(cfg_q.limit);
      REG_STEP:  prdata = DATA_W'(cfg_q.step);
      default:   prdata = '0;
    endcase
  end

endmodule

// File: sv/dbtm_biquad.sv
// One channel of the direct-form-I biquad, split into four pipeline stages.
// Depends on dbtm_pkg for the coefficient struct, load enables and widths.
module dbtm_biquad #(
  parameter int SAMPLE_BITS    = dbtm_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = dbtm_pkg::COEF_FRAC_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  dbtm_pkg::dbtm_ld_t                 ld_i,
  input  dbtm_pkg::dbtm_cfg_t                cfg_i,
  input  logic [SAMPLE_BITS-1:0]             x_i,
  output logic signed [dbtm_pkg::HIST_W-1:0] y_o
);
  import dbtm_pkg::*;

  localparam int XS_W   = SAMPLE_BITS + 1;
  localparam int PROD_W = COEF_W + XS_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int FF_W   = SUM_W + HIST_FRAC;
  localparam int FB_W   = COEF_W + HIST_W;
  localparam int ACC_W  = ((FF_W > FB_W) ? FF_W : FB_W) + 2;

  localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(HIST_MAX);
  localparam logic signed [ACC_W-1:0] Y_MIN = ACC_W'(HIST_MIN);

  logic [SAMPLE_BITS-1:0]     tap_q [3];
  logic signed [COEF_W-1:0]   coef_ff [3];
  logic signed [PROD_W-1:0]   prod_d [3];
  logic signed [PROD_W-1:0]   prod_q [3];
  logic signed [SUM_W-1:0]    sum_d;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [FB_W-1:0]     fb_cur;
  logic signed [FB_W-1:0]     a2y_d;
  logic signed [FB_W-1:0]     a2y_q;
  logic signed [ACC_W-1:0]    acc;
  logic signed [ACC_W-1:0]    y_floor;
  logic signed [HIST_W-1:0]   y_sat;
  logic signed [HIST_W-1:0]   y_q [2];

  // Stage 1: input sample and the two previous ones as a shift line.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q[0] <= '0;
      tap_q[1] <= '0;
      tap_q[2] <= '0;
    end else if (ld_i.s1) begin
      tap_q[0] <= x_i;
      tap_q[1] <= tap_q[0];
      tap_q[2] <= tap_q[1];
    end
  end

  // Stage 2: the three feedforward products, one multiplier per tap.
  always_comb begin
    coef_ff[0] = cfg_i.b0;
    coef_ff[1] = cfg_i.b1;
    coef_ff[2] = cfg_i.b2;
    for (int k = 0; k < 3; k++) begin
      prod_d[k] = coef_ff[k] * $signed({1'b0, tap_q[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      prod_q <= prod_d;
    end
  end

  // Stage 3: feedforward sum, still without the history scale.
  assign sum_d = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]);

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      sum_q <= sum_d;
    end
  end

  // Stage 4: recursive part. The a2 term is registered ahead of time from the
  // value that will be the older history entry once this stage loads.
  assign fb_cur = cfg_i.a1 * y_q[0];
  assign a2y_d  = cfg_i.a2 * (ld_i.s4 ? y_q[0] : y_q[1]);
  assign acc    = (ACC_W'(sum_q) <<< HIST_FRAC) + ACC_W'(fb_cur) + ACC_W'(a2y_q);
  assign y_floor = acc >>> COEF_FRAC_BITS;

  // Clamp the new output to the history range before it is stored.
  always_comb begin
    if (y_floor > Y_MAX) begin
      y_sat = HIST_W'(Y_MAX);
    end else if (y_floor < Y_MIN) begin
      y_sat = HIST_W'(Y_MIN);
    end else begin
      y_sat = HIST_W'(y_floor);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_q[0] <= '0;
      y_q[1] <= '0;
      a2y_q  <= '0;
    end else begin
      a2y_q <= a2y_d;
      if (ld_i.s4) begin
        y_q[0] <= y_sat;
        y_q[1] <= y_q[0];
      end
    end
  end

  assign y_o = y_q[0];

endmodule

// File: sv/dbtm_report.sv
// Output stage: converts both filter outputs to integers, flags them against
// the limit and forms their distance. Depends on dbtm_pkg for widths.
module dbtm_report (
  input  logic                               clk_i,
  input  logic                               ld_i,
  input  logic [dbtm_pkg::LIMIT_W-1:0]       limit_i,
  input  logic signed [dbtm_pkg::HIST_W-1:0] y_a_i,
  input  logic signed [dbtm_pkg::HIST_W-1:0] y_b_i,
  output logic signed [dbtm_pkg::FILT_W-1:0] filt_a_o,
  output logic signed [dbtm_pkg::FILT_W-1:0] filt_b_o,
  output logic [dbtm_pkg::FILT_W-1:0]        diff_o,
  output logic                               flag_a_o,
  output logic                               flag_b_o
);
  import dbtm_pkg::*;

  logic signed [FILT_W-1:0] whole_a;
  logic signed [FILT_W-1:0] whole_b;
  logic signed [FILT_W:0]   delta;
  logic signed [FILT_W:0]   delta_abs;
  logic signed [FILT_W-1:0] filt_a_q;
  logic signed [FILT_W-1:0] filt_b_q;
  logic [FILT_W-1:0]        diff_q;
  logic                     flag_a_q;
  logic                     flag_b_q;

  // Truncation toward zero: bias negative values before the arithmetic shift.
  // The history range already maps onto the 14-bit output range exactly.
  function automatic logic signed [FILT_W-1:0] to_whole(
    input logic signed [HIST_W-1:0] y
  );
    logic [HIST_W-1:0] biased;
    biased = y + (y[HIST_W-1] ? HIST_W'(2 ** HIST_FRAC - 1) : HIST_W'(0));
    return biased[HIST_W-1:HIST_FRAC];
  endfunction

  assign whole_a   = to_whole(y_a_i);
  assign whole_b   = to_whole(y_b_i);
  assign delta     = {whole_a[FILT_W-1], whole_a} - {whole_b[FILT_W-1], whole_b};
  assign delta_abs = delta[FILT_W] ? -delta : delta;

  // A negative value never exceeds the unsigned limit.
  always_ff @(posedge clk_i) begin
    if (ld_i) begin
      filt_a_q <= whole_a;
      filt_b_q <= whole_b;
      diff_q   <= delta_abs[FILT_W-1:0];
      flag_a_q <= !whole_a[FILT_W-1] && (whole_a[LIMIT_W-1:0] > limit_i);
      flag_b_q <= !whole_b[FILT_W-1] && (whole_b[LIMIT_W-1:0] > limit_i);
    end
  end

  assign filt_a_o = filt_a_q;
  assign filt_b_o = filt_b_q;
  assign diff_o   = diff_q;
  assign flag_a_o = flag_a_q;
  assign flag_b_o = flag_b_q;

endmodule

// File: sv/dual_biquad_threshold_monitor_core.sv
// Dual-channel biquad threshold monitor, top level. Instantiates dbtm_regs,
// two dbtm_biquad channels and dbtm_report; depends on dbtm_pkg.
//
// Each input word carries one sample per sensor and yields exactly one output
// word. The block takes a new word every cycle while the output side is not
// stalled: the pipeline is input taps, feedforward products, feedforward sum,
// the recursive stage and the output register, and the recursive stage closes
// the a1 multiply-add loop combinationally around its output register, so
// consecutive words need no spacing. Each stage advances on its own, so input
// words keep entering while empty stages remain behind a stalled output word.
// The user must write coefficients, limit and time step through the APB port
// only while no word is in flight; the block itself does not enforce this.
// The timestamp starts at zero after reset.
module dual_biquad_threshold_monitor_core #(
  parameter int SAMPLE_BITS    = dbtm_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_FRAC_BITS = dbtm_pkg::COEF_FRAC_DEF,
  localparam int IN_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = dbtm_pkg::STAMP_W + 2 * SAMPLE_BITS + 3 * dbtm_pkg::FILT_W + 4,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Input stream.
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // tdata from bit 0: sample_a, sample_b, zero pad.
  input  logic [IN_W-1:0]             s_axis_tdata,
  // Output stream.
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // tdata from bit 0: stamp_ms, raw_a, filtered_a, raw_b, filtered_b,
  // abs_difference, combined_state, led_a, led_b, zero pad.
  output logic [OUT_W-1:0]            m_axis_tdata,
  // Configuration port.
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dbtm_pkg::ADDR_W-1:0] paddr,
  input  logic [dbtm_pkg::DATA_W-1:0] pwdata,
  output logic [dbtm_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import dbtm_pkg::*;

  dbtm_cfg_t               cfg;
  dbtm_ld_t                ld_ch;
  logic [5:1]              v_q;
  logic [5:1]              v_d;
  logic [5:1]              rdy;
  logic [5:1]              nxt_rdy;
  logic [5:1]              ld;
  logic [STAMP_W-1:0]      stamp_q;
  logic [STAMP_W-1:0]      stamp_s [1:4];
  logic [SAMPLE_BITS-1:0]  raw_a_s [1:4];
  logic [SAMPLE_BITS-1:0]  raw_b_s [1:4];
  logic [STAMP_W-1:0]      out_stamp_q;
  logic [SAMPLE_BITS-1:0]  out_raw_a_q;
  logic [SAMPLE_BITS-1:0]  out_raw_b_q;
  logic [SAMPLE_BITS-1:0]  sample_a;
  logic [SAMPLE_BITS-1:0]  sample_b;
  logic signed [HIST_W-1:0] y_a;
  logic signed [HIST_W-1:0] y_b;
  logic signed [FILT_W-1:0] filt_a;
  logic signed [FILT_W-1:0] filt_b;
  logic [FILT_W-1:0]        diff;
  logic                     flag_a;
  logic                     flag_b;

  assign sample_a = s_axis_tdata[SAMPLE_BITS-1:0];
  assign sample_b = s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

  // Configuration registers.
  dbtm_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Pipeline control: a stage takes a word when it is empty or its word moves on.
  always_comb begin
    nxt_rdy[5] = m_axis_tready;
    rdy[5]     = !v_q[5] || m_axis_tready;
    for (int k = 4; k >= 1; k--) begin
      nxt_rdy[k] = rdy[k+1];
      rdy[k]     = !v_q[k] || rdy[k+1];
    end
    ld[1] = s_axis_tvalid && rdy[1];
    for (int k = 2; k <= 5; k++) begin
      ld[k] = v_q[k-1] && rdy[k];
    end
    for (int k = 1; k <= 5; k++) begin
      v_d[k] = ld[k] || (v_q[k] && !nxt_rdy[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign s_axis_tready = rdy[1];
  assign m_axis_tvalid = v_q[5];

  // Timestamp counter, sampled for each accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q <= '0;
    end else if (ld[1]) begin
      stamp_q <= stamp_q + STAMP_W'(cfg.step);
    end
  end

  // Timestamp and raw samples travel beside the filter stages.
  always_ff @(posedge clk_i) begin
    if (ld[1]) begin
      stamp_s[1] <= stamp_q;
      raw_a_s[1] <= sample_a;
      raw_b_s[1] <= sample_b;
    end
    for (int k = 2; k <= 4; k++) begin
      if (ld[k]) begin
        stamp_s[k] <= stamp_s[k-1];
        raw_a_s[k] <= raw_a_s[k-1];
        raw_b_s[k] <= raw_b_s[k-1];
      end
    end
    if (ld[5]) begin
      out_stamp_q <= stamp_s[4];
      out_raw_a_q <= raw_a_s[4];
      out_raw_b_q <= raw_b_s[4];
    end
  end

  // Filter channels.
  assign ld_ch = '{s1: ld[1], s2: ld[2], s3: ld[3], s4: ld[4]};

  dbtm_biquad #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_biquad_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ld_ch),
    .cfg_i  (cfg),
    .x_i    (sample_a),
    .y_o    (y_a)
  );

  dbtm_biquad #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_biquad_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ld_i   (ld_ch),
    .cfg_i  (cfg),
    .x_i    (sample_b),
    .y_o    (y_b)
  );

  // Output register with conversion, flags and distance.
  dbtm_report u_report (
    .clk_i    (clk_i),
    .ld_i     (ld[5]),
    .limit_i  (cfg.limit),
    .y_a_i    (y_a),
    .y_b_i    (y_b),
    .filt_a_o (filt_a),
    .filt_b_o (filt_b),
    .diff_o   (diff),
    .flag_a_o (flag_a),
    .flag_b_o (flag_b)
  );

  // Output word packing.
  assign m_axis_tdata = OUT_W'({flag_b, flag_a, flag_b, flag_a, diff, filt_b, out_raw_b_q,
                                filt_a, out_raw_a_q, out_stamp_q});

  // An empty output register means nothing can block the input side.
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while the output register is empty");

  // The timestamp advances by exactly one step per accepted word.
  a_stamp_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld[1] |=> stamp_q == $past(stamp_q) + STAMP_W'($past(cfg.step)))
    else $error("timestamp did not advance by the configured step");

  // An output word is only withdrawn after it has been taken.
  a_out_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(v_q[5]) |-> $past(m_axis_tready))
    else $error("output word dropped without a handshake");

endmodule
